// File: hw/rtl/lpcr_pkg.sv
package lpcr_pkg;

    typedef enum logic [1:0] {
        BAND_NORMAL,
        BAND_LOW,
        BAND_HIGH
    } cut_band_t;

    typedef struct packed {
        cut_band_t   band;
        logic [15:0] res_coeff;
    } side_t;

    localparam logic [13:0] CUT_LOW  = 14'd30;
    localparam logic [13:0] CUT_HIGH = 14'd8000;
    localparam logic [15:0] LOW_CODE  = 16'h8000;
    localparam logic [15:0] HIGH_CODE = 16'h0000;

    // pi * 2^30 / 48000 split into a whole part and a remainder over 48000.
    localparam logic [16:0] THETA_WHOLE = 17'd70276;
    localparam logic [13:0] THETA_FRAC  = 14'd11426;
    localparam logic [14:0] HALF_RATE   = 15'd24000;
    // 48000 = 2^7 * 375.
    localparam int unsigned RATE_SHIFT = 7;
    localparam logic [8:0]  RATE_ODD   = 9'd375;
    localparam logic [19:0] RECIP_375  = 20'd715827;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int unsigned HORNER_STEPS = 4;
    localparam int unsigned HORNER_SHIFT [HORNER_STEPS] = '{3, 1, 2, 1};
    localparam logic [6:0]  HORNER_ODD   [HORNER_STEPS] = '{7'd9, 7'd21, 7'd5, 7'd3};
    localparam logic [30:0] HORNER_RECIP [HORNER_STEPS] =
        '{31'd477218588, 31'd204522252, 31'd858993459, 31'd1431655765};

    localparam int unsigned LEAD_LOW_BIT = 21;
    localparam int unsigned LEAD_SPAN    = 9;
    localparam int unsigned SQUARE_STEPS = 20;

    localparam int unsigned PIPE_DEPTH = 4 + 3 * HORNER_STEPS + 2 + SQUARE_STEPS;

    localparam logic signed [7:0] RES_MIN = -8'sd6;
    localparam logic signed [7:0] RES_MAX = 8'sd22;
    localparam int unsigned RES_ENTRIES = 30;
    localparam logic [15:0] RES_TABLE [RES_ENTRIES] = '{
        16'd65380, 16'd58270, 16'd51933, 16'd46286, 16'd41252, 16'd36766,
        16'd32768, 16'd29204, 16'd26028, 16'd23197, 16'd20675, 16'd18426,
        16'd16422, 16'd14636, 16'd13045, 16'd11626, 16'd10362, 16'd9235,
        16'd8230,  16'd7335,  16'd6538,  16'd5827,  16'd5193,  16'd4628,
        16'd4125,  16'd3676,  16'd3276,  16'd2920,  16'd2602,  16'd2457
    };

    function automatic logic [15:0] resonance_code(logic signed [7:0] r);
        logic [15:0] code;
        if (r < RES_MIN)
        begin
            code = 16'hFFFF;
        end
        else if (r > RES_MAX)
        begin
            code = RES_TABLE[RES_ENTRIES - 1];
        end
        else
        begin
            code = RES_TABLE[5'(r - RES_MIN)];
        end
        return code;
    endfunction

endpackage

// File: hw/rtl/lpcr_in_if.sv
interface lpcr_in_if;
    logic              valid;
    logic              ready;
    logic [13:0]       cutoff_hz;
    logic signed [7:0] resonance_db;

    modport source (output valid, output cutoff_hz, output resonance_db, input ready);
    modport sink (input valid, input cutoff_hz, input resonance_db, output ready);
endinterface

// File: hw/rtl/lpcr_out_if.sv
interface lpcr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cutoff_coeff;
    logic [15:0] resonance_coeff;

    modport source (output valid, output cutoff_coeff, output resonance_coeff, input ready);
    modport sink (input valid, input cutoff_coeff, input resonance_coeff, output ready);
endinterface

// File: hw/rtl/lowpass_cutoff_resonance_coeff.sv
// Turns a cutoff in hertz and a resonance in decibels into the two 16-bit lowpass
// coefficients. The block takes one transfer on params in every clock while
// params.ready is high and returns one transfer on coeffs for each, in order;
// each result passes through the 38-stage datapath (angle, sine polynomial with
// reciprocal divisions, leading-one search and twenty squaring stages for log2)
// plus the output register. A skid register behind the output register lets the
// pipeline keep accepting while a result waits; params.ready falls only when both
// are full. There is no configuration and no state beyond the pipeline.
module lowpass_cutoff_resonance_coeff (
    input logic        clk,
    input logic        rst_n,
    lpcr_in_if.sink    params,
    lpcr_out_if.source coeffs
);
    import lpcr_pkg::*;

    localparam int unsigned NORM_STAGE = 4 + 3 * HORNER_STEPS + 1;

    logic                    pipe_en;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    side_t                   side_reg [PIPE_DEPTH];
    side_t                   side_in;
    logic [12:0]             f_in;

    logic [29:0] a1_next;
    logic [26:0] n1_next;
    logic [29:0] a1_reg;
    logic [19:0] m1_reg;

    logic [39:0] prod2;
    logic [11:0] q2_reg;
    logic [29:0] a2_reg;
    logic [19:0] m2_reg;

    logic [19:0] qd3;
    logic [19:0] r3;
    logic [29:0] theta3_next;
    logic [29:0] theta3_reg;

    logic [59:0] sq4;
    logic [28:0] x2_4_reg;
    logic [29:0] th4_reg;

    logic [28:0] hx_a_reg [HORNER_STEPS];
    logic [28:0] hx_b_reg [HORNER_STEPS];
    logic [28:0] hx_c_reg [HORNER_STEPS];
    logic [29:0] hth_a_reg [HORNER_STEPS];
    logic [29:0] hth_b_reg [HORNER_STEPS];
    logic [29:0] hth_c_reg [HORNER_STEPS];
    logic [28:0] hu_reg [HORNER_STEPS];
    logic [28:0] hy_reg [HORNER_STEPS];
    logic [27:0] hq_reg [HORNER_STEPS];
    logic [30:0] ht_reg [HORNER_STEPS];

    logic [60:0] prod_v;
    logic [29:0] v_reg;

    logic [3:0]  s_next;
    logic [30:0] mant_next;
    logic [3:0]  s_n_reg;
    logic [30:0] mant_reg;

    logic [30:0] sq_m_reg [SQUARE_STEPS];
    logic [19:0] sq_f_reg [SQUARE_STEPS];
    logic [3:0]  sq_s_reg [SQUARE_STEPS];

    logic [3:0]  s_fin;
    logic [19:0] f_fin;
    logic [23:0] mag;
    logic [15:0] cut_normal;
    logic [15:0] cut_final;

    logic        take;
    logic        arrive;
    logic        load_out;
    logic        load_skid;
    logic        out_from_skid;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic [15:0] out_cut_reg;
    logic [15:0] out_res_reg;
    logic [15:0] skid_cut_reg;
    logic [15:0] skid_res_reg;

    assign pipe_en      = !skid_valid_reg;
    assign params.ready = pipe_en;
    assign f_in         = params.cutoff_hz[12:0];

    always_comb
    begin
        if (params.cutoff_hz < CUT_LOW)
        begin
            side_in.band = BAND_LOW;
        end
        else if (params.cutoff_hz inside {[CUT_LOW:CUT_HIGH]})
        begin
            side_in.band = BAND_NORMAL;
        end
        else
        begin
            side_in.band = BAND_HIGH;
        end
        side_in.res_coeff = resonance_code(params.resonance_db);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], params.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // The angle is f * 70276 + round((f * 11426) / 48000), which equals the rounded
    // quotient of f * pi * 2^30 by 48000.
    assign a1_next = 30'(f_in) * 30'(THETA_WHOLE);
    assign n1_next = 27'(f_in) * 27'(THETA_FRAC) + 27'(HALF_RATE);

    assign prod2 = 40'(m1_reg) * 40'(RECIP_375);

    assign qd3         = 20'(32'(q2_reg) * 32'(RATE_ODD));
    assign r3          = m2_reg - qd3;
    assign theta3_next = a2_reg + 30'(q2_reg) + 30'(r3 >= 20'(RATE_ODD));

    assign sq4 = 60'(theta3_reg) * 60'(theta3_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a1_reg     <= a1_next;
            m1_reg     <= n1_next[26:RATE_SHIFT];
            q2_reg     <= prod2[39:28];
            a2_reg     <= a1_reg;
            m2_reg     <= m1_reg;
            theta3_reg <= theta3_next;
            x2_4_reg   <= sq4[58:30];
            th4_reg    <= theta3_reg;
        end
    end

    // Each Horner step forms x^2 * t, divides it by a constant through a
    // reciprocal product with one correction, and subtracts the quotient from one.
    for (genvar i = 0; i < HORNER_STEPS; i++)
    begin : g_horner
        logic [28:0] x_src;
        logic [29:0] th_src;
        logic [30:0] t_src;
        logic [59:0] prod_a;
        logic [28:0] y_next;
        logic [59:0] prod_b;
        logic [28:0] qd;
        logic [28:0] r;
        logic [30:0] t_next;

        if (i == 0)
        begin : g_first
            assign x_src  = x2_4_reg;
            assign th_src = th4_reg;
            assign t_src  = ONE_Q30;
        end
        else
        begin : g_rest
            assign x_src  = hx_c_reg[i-1];
            assign th_src = hth_c_reg[i-1];
            assign t_src  = ht_reg[i-1];
        end

        assign prod_a = 60'(x_src) * 60'(t_src);
        assign y_next = hu_reg[i] >> HORNER_SHIFT[i];
        assign prod_b = 60'(y_next) * 60'(HORNER_RECIP[i]);
        assign qd     = 29'(36'(hq_reg[i]) * 36'(HORNER_ODD[i]));
        assign r      = hy_reg[i] - qd;
        assign t_next = ONE_Q30 - (31'(hq_reg[i]) + 31'(r >= 29'(HORNER_ODD[i])));

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                hu_reg[i]    <= prod_a[58:30];
                hx_a_reg[i]  <= x_src;
                hth_a_reg[i] <= th_src;
                hy_reg[i]    <= y_next;
                hq_reg[i]    <= prod_b[59:32];
                hx_b_reg[i]  <= hx_a_reg[i];
                hth_b_reg[i] <= hth_a_reg[i];
                ht_reg[i]    <= t_next;
                hx_c_reg[i]  <= hx_b_reg[i];
                hth_c_reg[i] <= hth_b_reg[i];
            end
        end
    end

    assign prod_v = 61'(hth_c_reg[HORNER_STEPS-1]) * 61'(ht_reg[HORNER_STEPS-1]);

    // In the normal band the sine lies between 2^21 and 2^30 in Q30, so the
    // leading one is searched over nine places only.
    always_comb
    begin
        s_next = 4'(LEAD_SPAN - 1);
        for (int j = 0; j < LEAD_SPAN; j++)
        begin
            if (v_reg[LEAD_LOW_BIT + j])
            begin
                s_next = 4'(LEAD_SPAN - 1 - j);
            end
        end
        mant_next = 31'(v_reg) << (5'(s_next) + 5'd1);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            v_reg    <= prod_v[59:30];
            s_n_reg  <= s_next;
            mant_reg <= mant_next;
        end
    end

    for (genvar j = 0; j < SQUARE_STEPS; j++)
    begin : g_square
        logic [30:0] m_src;
        logic [19:0] f_src;
        logic [3:0]  s_src;
        logic [61:0] prod;
        logic [31:0] w;

        if (j == 0)
        begin : g_first
            assign m_src = mant_reg;
            assign f_src = '0;
            assign s_src = s_n_reg;
        end
        else
        begin : g_rest
            assign m_src = sq_m_reg[j-1];
            assign f_src = sq_f_reg[j-1];
            assign s_src = sq_s_reg[j-1];
        end

        assign prod = 62'(m_src) * 62'(m_src);
        assign w    = prod[61:30];

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                if (w[31])
                begin
                    sq_m_reg[j] <= w[31:1];
                end
                else
                begin
                    sq_m_reg[j] <= w[30:0];
                end
                sq_f_reg[j] <= {f_src[18:0], w[31]};
                sq_s_reg[j] <= s_src;
            end
        end
    end

    // The log2 total is negative whenever the leading one sits below bit 29, and
    // the division by 256 then truncates toward zero.
    assign s_fin      = sq_s_reg[SQUARE_STEPS-1];
    assign f_fin      = sq_f_reg[SQUARE_STEPS-1];
    assign mag        = {s_fin, 20'd0} - {4'd0, f_fin};
    assign cut_normal = (s_fin == 4'd0) ? {4'd0, f_fin[19:8]} : 16'd0 - mag[23:8];

    always_comb
    begin
        case (side_reg[PIPE_DEPTH-1].band)
            BAND_LOW:    cut_final = LOW_CODE;
            BAND_HIGH:   cut_final = HIGH_CODE;
            BAND_NORMAL: cut_final = cut_normal;
            default:     cut_final = cut_normal;
        endcase
    end

    assign take   = out_valid_reg && coeffs.ready;
    assign arrive = pipe_en && valid_reg[PIPE_DEPTH-1];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !coeffs.ready)
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
            else
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_cut_reg <= cut_final;
            out_res_reg <= side_reg[PIPE_DEPTH-1].res_coeff;
        end
        else if (out_from_skid)
        begin
            out_cut_reg <= skid_cut_reg;
            out_res_reg <= skid_res_reg;
        end
        if (load_skid)
        begin
            skid_cut_reg <= cut_final;
            skid_res_reg <= side_reg[PIPE_DEPTH-1].res_coeff;
        end
    end

    assign coeffs.valid           = out_valid_reg;
    assign coeffs.cutoff_coeff    = out_cut_reg;
    assign coeffs.resonance_coeff = out_res_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !coeffs.ready))
        else $error("Skid register filled without a stalled output.");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_reg))
        else $error("Pipeline moved while stalled.");

    a_mant_normalised: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NORM_STAGE] && side_reg[NORM_STAGE].band == BAND_NORMAL)
            |-> mant_reg[30])
        else $error("Log2 mantissa is not normalised.");

endmodule
